### rtl/rmq_pkg.sv
// shared widths, codes and word types for the rotation matrix to quaternion core
`timescale 1ns / 1ps
package rmq_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC       = DATA_WIDTH - 2;

    // candidate = sum of three elements, pair = sum of two elements
    localparam int CAND_W = DATA_WIDTH + 2;
    localparam int PAIR_W = DATA_WIDTH + 1;
    localparam int MAG_W  = DATA_WIDTH + 1;

    // radicand (big + one) << (frac - 2) and its integer root
    localparam int RAD_W  = 2 * DATA_WIDTH - 2;
    localparam int ROOT_W = DATA_WIDTH - 1;

    // scaled pair divided by twice the root
    localparam int NUM_W = 2 * DATA_WIDTH - 2;
    localparam int DEN_W = DATA_WIDTH;
    localparam int QUO_W = DATA_WIDTH;

    localparam logic [DATA_WIDTH-1:0] ONE_VAL = DATA_WIDTH'(1) << FRAC;

    typedef enum logic [1:0] {
        SEL_X = 2'd0,
        SEL_Y = 2'd1,
        SEL_Z = 2'd2,
        SEL_W = 2'd3
    } sel_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] m00;
        logic signed [DATA_WIDTH-1:0] m01;
        logic signed [DATA_WIDTH-1:0] m02;
        logic signed [DATA_WIDTH-1:0] m10;
        logic signed [DATA_WIDTH-1:0] m11;
        logic signed [DATA_WIDTH-1:0] m12;
        logic signed [DATA_WIDTH-1:0] m20;
        logic signed [DATA_WIDTH-1:0] m21;
        logic signed [DATA_WIDTH-1:0] m22;
    } matrix_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] qx;
        logic signed [DATA_WIDTH-1:0] qy;
        logic signed [DATA_WIDTH-1:0] qz;
        logic signed [DATA_WIDTH-1:0] qw;
    } quat_t;

endpackage

### rtl/rotation_matrix_to_quaternion_core.sv
// throughput: one word per cycle; the root and the three divides are bit-per-stage pipelines
// the whole pipeline holds while a finished word waits under stall
// reset clears only the valid bits; the payload registers keep running
// no memories, so no clearing pass after reset
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             matrix_valid,
    output logic             matrix_stall,
    input  rmq_pkg::matrix_t matrix,
    output logic             quat_valid,
    input  logic             quat_stall,
    output rmq_pkg::quat_t   quat
);
    import rmq_pkg::*;

    localparam int IDX_C = ROOT_W + 2;
    localparam int LAT   = ROOT_W + QUO_W + 4;

    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv          = !(vld_reg[LAT-1] && quat_stall);
    assign matrix_stall = !adv;
    assign quat_valid   = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], matrix_valid};
    end

    // stage a: candidates and off-diagonal pairs
    logic signed [CAND_W-1:0] cand_reg [4];
    logic signed [PAIR_W-1:0] s01_reg, s02_reg, s12_reg, d12_reg, d20_reg, d01_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cand_reg[0] <= CAND_W'(matrix.m00) - CAND_W'(matrix.m11) - CAND_W'(matrix.m22);
            cand_reg[1] <= CAND_W'(matrix.m11) - CAND_W'(matrix.m00) - CAND_W'(matrix.m22);
            cand_reg[2] <= CAND_W'(matrix.m22) - CAND_W'(matrix.m00) - CAND_W'(matrix.m11);
            cand_reg[3] <= CAND_W'(matrix.m00) + CAND_W'(matrix.m11) + CAND_W'(matrix.m22);
            s01_reg <= PAIR_W'(matrix.m01) + PAIR_W'(matrix.m10);
            s02_reg <= PAIR_W'(matrix.m20) + PAIR_W'(matrix.m02);
            s12_reg <= PAIR_W'(matrix.m12) + PAIR_W'(matrix.m21);
            d12_reg <= PAIR_W'(matrix.m12) - PAIR_W'(matrix.m21);
            d20_reg <= PAIR_W'(matrix.m20) - PAIR_W'(matrix.m02);
            d01_reg <= PAIR_W'(matrix.m01) - PAIR_W'(matrix.m10);
        end
    end

    // stage b: pick the largest candidate, earlier one on a tie
    logic signed [CAND_W-1:0] big;
    sel_t                     sel_next;
    logic signed [PAIR_W-1:0] pair [3];
    logic [RAD_W-1:0]         rad_next;
    logic [2:0][MAG_W-1:0]    mag_next;
    logic [2:0]               neg_next;

    always_comb
    begin
        big      = cand_reg[0];
        sel_next = SEL_X;
        if (cand_reg[1] > big)
        begin
            big      = cand_reg[1];
            sel_next = SEL_Y;
        end
        if (cand_reg[2] > big)
        begin
            big      = cand_reg[2];
            sel_next = SEL_Z;
        end
        if (cand_reg[3] > big)
        begin
            big      = cand_reg[3];
            sel_next = SEL_W;
        end
    end

    always_comb
    begin
        unique case (sel_next)
            SEL_X:
            begin
                pair[0] = s01_reg;
                pair[1] = s02_reg;
                pair[2] = d12_reg;
            end
            SEL_Y:
            begin
                pair[0] = s01_reg;
                pair[1] = s12_reg;
                pair[2] = d20_reg;
            end
            SEL_Z:
            begin
                pair[0] = s02_reg;
                pair[1] = s12_reg;
                pair[2] = d01_reg;
            end
            default:
            begin
                pair[0] = d12_reg;
                pair[1] = d20_reg;
                pair[2] = d01_reg;
            end
        endcase
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            neg_next[j] = pair[j][PAIR_W-1];
            mag_next[j] = MAG_W'($unsigned(pair[j][PAIR_W-1] ? -pair[j] : pair[j]));
        end
    end

    // big is never negative since the candidates sum to zero
    assign rad_next = (RAD_W'($unsigned(big)) + RAD_W'(ONE_VAL)) << (FRAC - 2);

    sel_t                  sel_b_reg;
    logic [RAD_W-1:0]      rad_b_reg;
    logic [2:0][MAG_W-1:0] mag_b_reg;
    logic [2:0]            neg_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_b_reg <= sel_next;
            rad_b_reg <= rad_next;
            mag_b_reg <= mag_next;
            neg_b_reg <= neg_next;
        end
    end

    // root pipeline with side data carried alongside
    logic [ROOT_W-1:0] root;

    rmq_sqrt_pipe u_sqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (rad_b_reg),
        .root     (root)
    );

    sel_t                  sel_s_reg [ROOT_W];
    logic [2:0][MAG_W-1:0] mag_s_reg [ROOT_W];
    logic [2:0]            neg_s_reg [ROOT_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_s_reg[0] <= sel_b_reg;
            mag_s_reg[0] <= mag_b_reg;
            neg_s_reg[0] <= neg_b_reg;
            for (int i = 1; i < ROOT_W; i++)
            begin
                sel_s_reg[i] <= sel_s_reg[i-1];
                mag_s_reg[i] <= mag_s_reg[i-1];
                neg_s_reg[i] <= neg_s_reg[i-1];
            end
        end
    end

    // stage c: scaled pair plus half divisor for round half away from zero
    logic [NUM_W-1:0]  num_c_reg [3];
    logic [DEN_W-1:0]  den_c_reg;
    logic [ROOT_W-1:0] root_c_reg;
    sel_t              sel_c_reg;
    logic [2:0]        neg_c_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
                num_c_reg[j] <= (NUM_W'(mag_s_reg[ROOT_W-1][j]) << (FRAC - 1)) + NUM_W'(root);
            den_c_reg  <= {root, 1'b0};
            root_c_reg <= root;
            sel_c_reg  <= sel_s_reg[ROOT_W-1];
            neg_c_reg  <= neg_s_reg[ROOT_W-1];
        end
    end

    logic [QUO_W-1:0] quo [3];

    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        rmq_div_pipe u_div (
            .clk (clk),
            .en  (adv),
            .num (num_c_reg[j]),
            .den (den_c_reg),
            .quo (quo[j])
        );
    end

    logic [ROOT_W-1:0] root_d_reg [QUO_W];
    sel_t              sel_d_reg  [QUO_W];
    logic [2:0]        neg_d_reg  [QUO_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            root_d_reg[0] <= root_c_reg;
            sel_d_reg[0]  <= sel_c_reg;
            neg_d_reg[0]  <= neg_c_reg;
            for (int i = 1; i < QUO_W; i++)
            begin
                root_d_reg[i] <= root_d_reg[i-1];
                sel_d_reg[i]  <= sel_d_reg[i-1];
                neg_d_reg[i]  <= neg_d_reg[i-1];
            end
        end
    end

    // final stage: saturate, apply sign, place the root component
    function automatic logic [DATA_WIDTH-1:0] lane_val(input logic [QUO_W-1:0] q,
                                                       input logic n);
        logic [QUO_W-1:0] m;
        m = (q > QUO_W'(ONE_VAL)) ? QUO_W'(ONE_VAL) : q;
        return n ? DATA_WIDTH'(-m) : DATA_WIDTH'(m);
    endfunction

    logic [DATA_WIDTH-1:0] l0, l1, l2, rv;
    quat_t                 quat_next;
    quat_t                 quat_reg;

    assign l0 = lane_val(quo[0], neg_d_reg[QUO_W-1][0]);
    assign l1 = lane_val(quo[1], neg_d_reg[QUO_W-1][1]);
    assign l2 = lane_val(quo[2], neg_d_reg[QUO_W-1][2]);
    assign rv = (root_d_reg[QUO_W-1] > ROOT_W'(ONE_VAL)) ? ONE_VAL
                                                         : {1'b0, root_d_reg[QUO_W-1]};

    always_comb
    begin
        unique case (sel_d_reg[QUO_W-1])
            SEL_X:   quat_next = {rv, l0, l1, l2};
            SEL_Y:   quat_next = {l0, rv, l1, l2};
            SEL_Z:   quat_next = {l0, l1, rv, l2};
            default: quat_next = {l0, l1, l2, rv};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            quat_reg <= quat_next;
    end

    assign quat = quat_reg;

`ifndef SYNTHESIS
    localparam logic signed [DATA_WIDTH-1:0] POS_ONE = ONE_VAL;
    localparam logic signed [DATA_WIDTH-1:0] NEG_ONE = -ONE_VAL;

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid |-> quat.qx <= POS_ONE && quat.qx >= NEG_ONE &&
                       quat.qy <= POS_ONE && quat.qy >= NEG_ONE &&
                       quat.qz <= POS_ONE && quat.qz >= NEG_ONE &&
                       quat.qw <= POS_ONE && quat.qw >= NEG_ONE)
        else $error("quaternion component outside plus or minus one");

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[IDX_C] |-> root_c_reg >= ROOT_W'(ONE_VAL >> 1))
        else $error("root below one half, divisor too small");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        matrix_stall |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during stall");
`endif

endmodule

### rtl/rmq_sqrt_pipe.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module rmq_sqrt_pipe (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rmq_pkg::RAD_W-1:0]  radicand,
    output logic [rmq_pkg::ROOT_W-1:0] root
);
    import rmq_pkg::*;

    logic [RAD_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - k;

        logic [RAD_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W:0]    trial;
        logic              take;
        logic [RAD_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // (r + 2^b)^2 - r^2, root bits only sit above b
        assign trial     = ((RAD_W+1)'(root_in) << (B + 1)) | ((RAD_W+1)'(1) << (2 * B));
        assign take      = {1'b0, rem_in} >= trial;
        assign rem_next  = take ? rem_in - trial[RAD_W-1:0] : rem_in;
        assign root_next = root_in | (ROOT_W'(take) << B);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

### rtl/rmq_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module rmq_div_pipe (
    input  logic                      clk,
    input  logic                      en,
    input  logic [rmq_pkg::NUM_W-1:0] num,
    input  logic [rmq_pkg::DEN_W-1:0] den,
    output logic [rmq_pkg::QUO_W-1:0] quo
);
    import rmq_pkg::*;

    localparam int XW = DEN_W + QUO_W;

    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        localparam int B = QUO_W - 1 - i;

        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [XW-1:0]    trial;
        logic             take;
        logic [NUM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (i == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        assign trial    = XW'(den_in) << B;
        assign take     = XW'(rem_in) >= trial;
        assign rem_next = take ? rem_in - trial[NUM_W-1:0] : rem_in;
        assign quo_next = quo_in | (QUO_W'(take) << B);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_in;
                quo_reg[i] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule
